### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// a property checked only while reset is asserted
`define CHK_RESET(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) (!rst_n) |-> (prop)) \
        else $error("%m: reset check failed");

`endif

### hw/rtl/tgs_pkg.sv
// package of the trilinear grid sampler: constants, types, helpers
package tgs_pkg;

    localparam int GRID_DIM_DEF = 32;
    localparam int ADDR_W       = 15;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int CPU_W        = 24;
    localparam logic [CPU_W-1:0] CPU_RESET = 24'd65536;

    // action codes of an input item
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_READ,
        ST_LERP,
        ST_OUT
    } state_t;

    // one lerp request to the shared blend unit
    typedef struct packed {
        logic               start;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [15:0]        f;
    } lerp_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -50'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

### hw/rtl/tgs_lerp.sv
// shared lerp unit: a*(1-f) + b*f rounded; products and start are registered
module tgs_lerp
    import tgs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lerp_req_t          req,
    output logic               done,
    output logic signed [31:0] result
);

    logic signed [49:0] pa_reg, pb_reg;
    logic               stage_reg;
    logic signed [50:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= 1'b0;
        else
            stage_reg <= req.start;
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            pa_reg <= req.a * $signed({1'b0, 17'd65536 - {1'b0, req.f}});
            pb_reg <= req.b * $signed({2'b0, req.f});
        end
    end

    // convex combination of 32-bit values stays in 32 bits after the shift
    assign sum    = {pa_reg[49], pa_reg} + {pb_reg[49], pb_reg} + 51'sd32768;
    assign done   = stage_reg;
    assign result = sum[47:16];

endmodule

### hw/rtl/trilinear_grid_sampler_top.sv
// top level of the trilinear grid sampler
//
// channel   dir  handshake        payload
// in        in   valid / stall    action, cell_index, cell_v*, pos_*
// out       out  out_valid/stall  sample_vx, sample_vy, sample_vz
// cfg       in   valid / ready    cfg_data (cells_per_unit)
//
// a write item goes straight into the grid memories
// a sample holds the input through the axis split (a multiply and a clamp per
// axis), 8 reads plus the landing of the last, 21 lerp steps, each run on
// the single shared lerp multiplier pair, and the handoff into the output register
// the result is offered from the cycle after the handoff into the output register
// a result waiting in the output register stalls the input only once the
// next sample is finished too
// reset clears control and sets cells_per_unit to 1.0; grid is undefined
module trilinear_grid_sampler_top
    import tgs_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [14:0]        cell_index,
    input  logic signed [31:0] cell_vx,
    input  logic signed [31:0] cell_vy,
    input  logic signed [31:0] cell_vz,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sample_vx,
    output logic signed [31:0] sample_vy,
    output logic signed [31:0] sample_vz,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);

    localparam int CW = $clog2(GRID_DIM);

    // grid memories, one per component
    logic [31:0] mem_x [STORE_DEPTH];
    logic [31:0] mem_y [STORE_DEPTH];
    logic [31:0] mem_z [STORE_DEPTH];

    state_t state_reg, state_next;
    logic [CPU_W-1:0] cpu_reg;
    logic signed [31:0] pos_reg [3];
    logic [CW-1:0] base_reg [3];
    logic [15:0]   frac_reg [3];
    logic [1:0]  axis_reg;
    logic        axis_ph_reg;
    logic signed [56:0] prod_reg;
    logic [3:0]  rd_cnt_reg;      // counts 8 reads and the landing of the last
    logic [2:0]  rd_idx_reg;
    logic        rd_vld_reg;
    logic [31:0] rdx_reg, rdy_reg, rdz_reg;
    logic signed [31:0] cx_reg [8];
    logic signed [31:0] cy_reg [8];
    logic signed [31:0] cz_reg [8];
    logic [4:0]  lstep_reg;       // 21 lerp steps: 7 per component
    logic        lbusy_reg;
    logic signed [31:0] res_reg [3];
    logic signed [31:0] out_reg [3];
    logic        out_valid_reg;

    lerp_req_t   lreq;
    logic        ldone;
    logic signed [31:0] lres;

    tgs_lerp u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (lreq),
        .done   (ldone),
        .result (lres)
    );

    logic in_acc;
    logic handoff;
    assign in_acc    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    // finished sample moves to the output register once that is empty or being read out
    assign handoff   = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample_vx = out_reg[0];
    assign sample_vy = out_reg[1];
    assign sample_vz = out_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cpu_reg <= CPU_RESET;
        else if (cfg_valid && cfg_ready)
            cpu_reg <= cfg_data;
    end

    // write port and sequential read port
    logic [ADDR_W-1:0] rd_addr;
    logic [CW:0] ox, oy, oz;
    logic [31:0] flat;
    always_comb
    begin
        ox = {1'b0, base_reg[0]} + {{CW{1'b0}}, rd_idx_reg[0]};
        oy = {1'b0, base_reg[1]} + {{CW{1'b0}}, rd_idx_reg[1]};
        oz = {1'b0, base_reg[2]} + {{CW{1'b0}}, rd_idx_reg[2]};
        flat = 32'(ox) + 32'(oy) * 32'(GRID_DIM) + 32'(oz) * 32'(GRID_DIM * GRID_DIM);
        rd_addr = flat[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && action == ACT_WRITE)
        begin
            mem_x[cell_index] <= cell_vx;
            mem_y[cell_index] <= cell_vy;
            mem_z[cell_index] <= cell_vz;
        end
        rdx_reg <= mem_x[rd_addr];
        rdy_reg <= mem_y[rd_addr];
        rdz_reg <= mem_z[rd_addr];
    end

    // axis split: scaled = floor(pos*cpu/2^16) - half, clamp to [1, dim-2]
    logic signed [41:0] scaled;
    logic signed [41:0] clamped;
    localparam logic signed [41:0] LO = 42'sd65536;
    localparam logic signed [41:0] HI = 42'(GRID_DIM - 2) <<< 16;
    always_comb
    begin
        scaled = 42'(prod_reg >>> 16) - 42'sd32768;
        if (scaled < LO)
            clamped = LO;
        else if (scaled > HI)
            clamped = HI;
        else
            clamped = scaled;
    end

    // lerp schedule per component: 4 x-lerps, 2 y-lerps, 1 z-lerp
    logic [1:0] comp;
    logic [2:0] sub;
    logic signed [31:0] ca [8];
    logic signed [31:0] tmp_reg [6];
    always_comb
    begin
        comp = 2'd0;
        if (lstep_reg >= 5'd14)
            comp = 2'd2;
        else if (lstep_reg >= 5'd7)
            comp = 2'd1;
        sub = 3'(lstep_reg - 5'(comp) * 5'd7);
        unique case (comp)
            2'd1:    ca = cy_reg;
            2'd2:    ca = cz_reg;
            default: ca = cx_reg;
        endcase
        lreq.start = (state_reg == ST_LERP) && !lbusy_reg;
        lreq.a = '0;
        lreq.b = '0;
        lreq.f = frac_reg[0];
        unique case (sub)
            3'd0, 3'd1, 3'd2, 3'd3:
            begin
                // pair index = dy + 2*dz; cells ordered dx + 2dy + 4dz
                lreq.a = ca[{sub[1:0], 1'b0}];
                lreq.b = ca[{sub[1:0], 1'b1}];
                lreq.f = frac_reg[0];
            end
            3'd4:
            begin
                lreq.a = tmp_reg[0];
                lreq.b = tmp_reg[1];
                lreq.f = frac_reg[1];
            end
            3'd5:
            begin
                lreq.a = tmp_reg[2];
                lreq.b = tmp_reg[3];
                lreq.f = frac_reg[1];
            end
            default:
            begin
                lreq.a = tmp_reg[4];
                lreq.b = tmp_reg[5];
                lreq.f = frac_reg[2];
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc && action == ACT_SAMPLE) state_next = ST_AXIS;
            ST_AXIS: if (axis_ph_reg && axis_reg == 2'd2) state_next = ST_READ;
            ST_READ: if (rd_cnt_reg == 4'd8) state_next = ST_LERP;
            ST_LERP: if (ldone && lstep_reg == 5'd20) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            axis_ph_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            lstep_reg     <= '0;
            lbusy_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_READ) && (rd_cnt_reg < 4'd8);
            unique case (state_reg)
                ST_IDLE:
                begin
                    axis_reg    <= '0;
                    axis_ph_reg <= 1'b0;
                    rd_cnt_reg  <= '0;
                    rd_idx_reg  <= '0;
                    lstep_reg   <= '0;
                    lbusy_reg   <= 1'b0;
                end
                ST_AXIS:
                begin
                    axis_ph_reg <= !axis_ph_reg;
                    if (axis_ph_reg)
                        axis_reg <= axis_reg + 2'd1;
                end
                ST_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 4'd1;
                    rd_idx_reg <= rd_idx_reg + 3'd1;
                end
                ST_LERP:
                begin
                    if (lreq.start)
                        lbusy_reg <= 1'b1;
                    else if (ldone)
                    begin
                        lbusy_reg <= 1'b0;
                        lstep_reg <= lstep_reg + 5'd1;
                    end
                end
                default: ;
            endcase
            if (handoff)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    logic [2:0] wr_idx;
    assign wr_idx = rd_idx_reg - 3'd1;
    always_ff @(posedge clk)
    begin
        if (in_acc && action == ACT_SAMPLE)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
        if (state_reg == ST_AXIS)
        begin
            if (!axis_ph_reg)
                prod_reg <= pos_reg[axis_reg] * $signed({1'b0, cpu_reg});
            else
            begin
                base_reg[axis_reg] <= CW'(clamped >>> 16);
                frac_reg[axis_reg] <= clamped[15:0];
            end
        end
        if (rd_vld_reg)
        begin
            cx_reg[wr_idx] <= rdx_reg;
            cy_reg[wr_idx] <= rdy_reg;
            cz_reg[wr_idx] <= rdz_reg;
        end
        if (state_reg == ST_LERP && ldone)
        begin
            if (sub == 3'd6)
                res_reg[comp] <= sat32(50'(lres));
            else
                tmp_reg[sub] <= lres;
        end
        if (handoff)
        begin
            out_reg[0] <= res_reg[0];
            out_reg[1] <= res_reg[1];
            out_reg[2] <= res_reg[2];
        end
    end

endmodule

### hw/rtl/tgs_checker.sv
// port-level checker for the trilinear grid sampler, bound to the top level
`include "assert_macros.svh"
module tgs_checker
    import tgs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        action,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] sample_vx
);

    `CHK_RESET(a_rst_out, clk, rst_n, !out_valid)
    `CHK_ALWAYS(a_out_keep, clk, rst_n, (out_valid && out_stall) |=> out_valid)
    `CHK_ALWAYS(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> $stable(sample_vx))
    `CHK_ALWAYS(a_sample_busy, clk, rst_n, (in_valid && !in_stall && action) |=> in_stall)
    `CHK_ALWAYS(a_write_free, clk, rst_n, (in_valid && !in_stall && !action) |=> !in_stall)

endmodule

bind trilinear_grid_sampler_top tgs_checker u_tgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_vx (sample_vx)
);
